// File: hdl/lkvc_pkg.sv
// Package for the LRU key-value cache: sizes, payload types and the cell control word.
// Used by lkvc_cell, lru_key_value_cache and lkvc_checker. Depends on nothing.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int DATA_W = 32;
    localparam int CAP_W = 5;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [OCC_W-1:0] occ_t;
    typedef logic [CAP_W-1:0] cap_t;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    localparam data_t MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic shift;
        logic ins_evict;
    } cell_ctrl_t;

endpackage

// File: hdl/lkvc_cell.sv
// One slot of the recency-ordered entry chain: key, value and valid bit.
// Depends on lkvc_pkg. Takes its neighbor's entry when told to shift.
module lkvc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  lkvc_pkg::cell_ctrl_t ctrl,
    input  lkvc_pkg::data_t     lookup_key,
    input  lkvc_pkg::data_t     prev_key,
    input  lkvc_pkg::data_t     prev_value,
    input  logic                prev_valid,
    input  logic                next_valid,
    output lkvc_pkg::data_t     key,
    output lkvc_pkg::data_t     value,
    output logic                valid,
    output logic                match,
    output logic                last
);
    import lkvc_pkg::*;

    data_t key_reg;
    data_t value_reg;
    logic  valid_reg;
    logic  valid_next;

    assign key   = key_reg;
    assign value = value_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (key_reg == lookup_key);
    assign last  = valid_reg && !next_valid;

    // The slot that would become newly occupied stays empty when the insert evicts.
    assign valid_next = ctrl.shift ? (prev_valid && !(ctrl.ins_evict && !valid_reg))
                                   : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

endmodule

// File: hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and lkvc_cell; the entries live in a chain of cells.
//
//   Channel  Ports                                            Handshake
//   input    s_cmd, s_lookup_key, s_write_value               s_valid / s_ready
//   result   m_found, m_read_value, m_evicted, m_evicted_key  m_valid / m_ready
//   config   cfg_wr_data (capacity)                           cfg_wr_en
//
// For each word all cells compare the key in parallel, the chain shifts
// at the accepting edge and the result lands in the output register.
// A new word is taken while a result waits only if m_ready takes it in the same cycle.
// Reset clears all valid bits and the occupancy at once; no clearing pass is needed.
module lru_key_value_cache (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  lkvc_pkg::data_t     s_lookup_key,
    input  lkvc_pkg::data_t     s_write_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output lkvc_pkg::data_t     m_read_value,
    output logic                m_evicted,
    output lkvc_pkg::data_t     m_evicted_key,
    input  logic                cfg_wr_en,
    input  lkvc_pkg::cap_t      cfg_wr_data
);
    import lkvc_pkg::*;

    cap_t  cap_reg;
    occ_t  occ_reg;
    occ_t  occ_next;
    logic  out_valid_reg;
    logic  found_reg;
    data_t read_value_reg;
    logic  evicted_reg;
    data_t evicted_key_reg;

    data_t      cell_key   [ENTRIES];
    data_t      cell_value [ENTRIES];
    data_t      prev_key   [ENTRIES];
    data_t      prev_value [ENTRIES];
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] prev_valid;
    logic [ENTRIES-1:0] next_valid;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] last;
    cell_ctrl_t         ctrl [ENTRIES];

    logic        accept;
    logic        hit;
    logic        is_put;
    logic        insert;
    logic        evict;
    logic [CMP_W-1:0] eff_cap;
    data_t       hit_value;
    data_t       last_key;
    data_t       front_value;
    data_t       read_value;
    data_t       evicted_key;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_put  = (cmd_t'(s_cmd) == CMD_PUT);
    assign hit     = |match;
    assign insert  = is_put && !hit;

    assign eff_cap = (CMP_W'(cap_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_reg);
    assign evict   = insert && (CMP_W'(occ_reg) >= eff_cap);

    always_comb begin
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | (match[i] ? cell_value[i] : '0);
            last_key  = last_key | (last[i] ? cell_key[i] : '0);
        end
    end

    assign front_value = is_put ? s_write_value : hit_value;
    assign read_value  = is_put ? '0 : (hit ? hit_value : MISS_VALUE);
    assign evicted_key = !evict ? '0 : ((|cell_valid) ? last_key : s_lookup_key);

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : gen_cell
            if (g == 0) begin : gen_head
                assign prev_key[g]   = s_lookup_key;
                assign prev_value[g] = front_value;
                assign prev_valid[g] = 1'b1;
            end else begin : gen_body
                assign prev_key[g]   = cell_key[g-1];
                assign prev_value[g] = cell_value[g-1];
                assign prev_valid[g] = cell_valid[g-1];
            end
            if (g == ENTRIES - 1) begin : gen_tail
                assign next_valid[g] = 1'b0;
            end else begin : gen_inner
                assign next_valid[g] = cell_valid[g+1];
            end

            // A hit promotes the slots from the front down to the matching one.
            assign ctrl[g].shift     = accept && ((hit && |(match >> g)) || insert);
            assign ctrl[g].ins_evict = evict;

            lkvc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl[g]),
                .lookup_key (s_lookup_key),
                .prev_key   (prev_key[g]),
                .prev_value (prev_value[g]),
                .prev_valid (prev_valid[g]),
                .next_valid (next_valid[g]),
                .key        (cell_key[g]),
                .value      (cell_value[g]),
                .valid      (cell_valid[g]),
                .match      (match[g]),
                .last       (last[g])
            );
        end
    endgenerate

    assign occ_next = (accept && insert && !evict) ? occ_reg + occ_t'(1) : occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            occ_reg <= occ_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            found_reg       <= hit;
            read_value_reg  <= read_value;
            evicted_reg     <= evict;
            evicted_key_reg <= evicted_key;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = found_reg;
    assign m_read_value  = read_value_reg;
    assign m_evicted     = evicted_reg;
    assign m_evicted_key = evicted_key_reg;

endmodule

// File: hdl/lkvc_checker.sv
// Port-level checks for lru_key_value_cache, bound to the top level.
// Depends on lkvc_pkg and sees only the top level's ports.
module lkvc_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            s_cmd,
    input logic            m_valid,
    input logic            m_ready,
    input logic            m_found,
    input lkvc_pkg::data_t m_read_value,
    input logic            m_evicted,
    input lkvc_pkg::data_t m_evicted_key
);
    import lkvc_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value) && $stable(m_evicted_key)))
        else $error("stalled result word changed");

    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted) |-> !m_found)
        else $error("eviction reported on a hit");

    a_no_evict_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

    a_get_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (cmd_t'(s_cmd) == CMD_GET)) |=>
            (m_valid && !m_evicted && (m_found || (m_read_value == MISS_VALUE))))
        else $error("bad result word for a get");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_cmd         (s_cmd),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_read_value  (m_read_value),
    .m_evicted     (m_evicted),
    .m_evicted_key (m_evicted_key)
);
